### src/fci_pkg.sv
// ============================================================================
// fci_pkg : shared types and constants of the flash command interface
// Transaction payloads, controller/datapath handshake structs, command bytes,
// unlock addresses and array geometry.
// ============================================================================
`default_nettype none

package fci_pkg;

    // array geometry
    localparam int PAGES_DEF   = 64;
    localparam int PAGE_BYTES  = 16384;
    localparam int ROW_BYTES   = 32;
    localparam int ROW_W       = ROW_BYTES * 8;
    localparam int LANE_W      = 5;                 // byte lane within a row
    localparam int ROW_SEL_W   = 14 - LANE_W;       // row within a page
    localparam int ROWS_PER_PG = PAGE_BYTES / ROW_BYTES;

    // bus operation codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_FETCH = 2'd2;

    // unlock addresses (low 12 bits of the offset)
    localparam logic [11:0] ADDR_UNLOCK1 = 12'hAAA;
    localparam logic [11:0] ADDR_UNLOCK2 = 12'h555;

    // command bytes
    localparam logic [7:0] BYTE_UNLOCK1 = 8'hAA;
    localparam logic [7:0] BYTE_UNLOCK2 = 8'h55;
    localparam logic [7:0] BYTE_PROGRAM = 8'hA0;
    localparam logic [7:0] BYTE_ERASE   = 8'h80;
    localparam logic [7:0] BYTE_FAST    = 8'h20;
    localparam logic [7:0] BYTE_AUTOSEL = 8'h90;
    localparam logic [7:0] BYTE_CHIP    = 8'h10;
    localparam logic [7:0] BYTE_SECTOR  = 8'h30;
    localparam logic [7:0] BYTE_RESET   = 8'hF0;

    // autoselect identification
    localparam logic [13:0] AS_OFF_MFR    = 14'd0;
    localparam logic [13:0] AS_OFF_DEVICE = 14'd2;
    localparam logic [13:0] AS_OFF_PROT   = 14'd4;
    localparam logic [7:0]  ID_MFR        = 8'h01;
    localparam logic [7:0]  ID_DEVICE     = 8'hDA;
    localparam logic [7:0]  ID_PROT       = 8'h00;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  page;
        logic [13:0] offset;
        logic [7:0]  wdata;
    } t_in_item;

    typedef struct packed {
        logic [7:0] rdata;
        logic       error_pending;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic lookup;
        logic decide;
        logic sweep_step;
        logic emit;
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic erase_req;
        logic sweep_done;
        logic out_free;
    } t_ctl_sts;

endpackage

`default_nettype wire

### src/fci_ram.sv
// ============================================================================
// fci_ram : generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module fci_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### src/fci_ctrl.sv
// ============================================================================
// fci_ctrl : transaction sequencer
// Steps each transaction through row lookup, decode, optional erase sweep
// and result hand-off; runs the array fill pass after reset.
// ============================================================================
`default_nettype none

module fci_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire fci_pkg::t_ctl_sts i_sts,
    output fci_pkg::t_ctl_cmd      o_ctl
);

    import fci_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_DECIDE,
        S_SWEEP,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_ctl.sweep_step = 1'b1;
                if (i_sts.sweep_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ctl.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_ctl.lookup = 1'b1;
                n_state      = S_DECIDE;
            end
            S_DECIDE: begin
                o_ctl.decide = 1'b1;
                n_state      = i_sts.erase_req ? S_SWEEP : S_EMIT;
            end
            S_SWEEP: begin
                o_ctl.sweep_step = 1'b1;
                if (i_sts.sweep_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_ctl.emit = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

### src/fci_dp.sv
// ============================================================================
// fci_dp : flash command datapath
// Holds the captured transaction, the unlock-sequence decoder, the program
// status registers, the array RAM, the erase sweep counter and the output
// register.
// ============================================================================
`default_nettype none

module fci_dp #(
    parameter int PAGES = fci_pkg::PAGES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fci_pkg::t_ctl_cmd  i_ctl,
    output fci_pkg::t_ctl_sts       o_sts,
    input  wire fci_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output fci_pkg::t_out_item      o_out_data
);

    import fci_pkg::*;

    localparam int PG_W     = $clog2(PAGES);
    localparam int ROW_AW   = PG_W + ROW_SEL_W;
    localparam int CNT_W    = ROW_AW + 1;
    localparam int DEPTH    = PAGES * ROWS_PER_PG;
    localparam int FULL_ROW = PAGES * ROWS_PER_PG;
    localparam int BOOT_ROW = (PAGES - 4) * ROWS_PER_PG;
    localparam int P2_ROW   = (PAGES - 2) * ROWS_PER_PG;
    localparam int P1_ROW   = (PAGES - 1) * ROWS_PER_PG;
    localparam int BLK_ROWS = 4 * ROWS_PER_PG;
    localparam int HALF_PG  = ROWS_PER_PG / 2;

    typedef enum logic [3:0] {
        ST_READ      = 4'd0,
        ST_AA        = 4'd1,
        ST_55        = 4'd2,
        ST_PROGRAM   = 4'd3,
        ST_ERASE     = 4'd4,
        ST_ERASE_AA  = 4'd5,
        ST_ERASE_55  = 4'd6,
        ST_AUTOSEL   = 4'd7,
        ST_FAST      = 4'd8,
        ST_FAST_EXIT = 4'd9,
        ST_FAST_PROG = 4'd10
    } t_step;

    // captured transaction
    logic [1:0]      r_cmd;
    logic [PG_W-1:0] r_pg;
    logic [13:0]     r_off;
    logic [7:0]      r_wd;

    // decoder and status state
    t_step      r_step;
    t_step      n_step;
    logic       r_perr;
    logic       n_perr;
    logic [7:0] r_lpb;
    logic [7:0] n_lpb;
    logic       r_tog;
    logic       n_tog;
    logic [7:0] r_res;
    logic [7:0] n_res;

    // erase sweep
    logic [CNT_W-1:0] r_sweep_row;
    logic [CNT_W-1:0] r_sweep_end;
    logic [CNT_W-1:0] sec_start;
    logic [CNT_W-1:0] sec_end;
    logic [CNT_W-1:0] aligned;
    logic             erase_req;
    logic             full_erase;

    // output register
    logic      r_out_valid;
    t_out_item r_out_data;

    // array access
    logic [8:0]        pg_mod;
    logic [ROW_AW-1:0] row;
    logic [ROW_W-1:0]  ram_rdata;
    logic [ROW_W-1:0]  merged;
    logic [7:0]        cur_byte;
    logic [7:0]        prog_byte;
    logic              prog_we;
    logic [11:0]       low;
    logic              ram_we;
    logic [ROW_AW-1:0] ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;

    // page number folded into the array, at most eight subtract steps
    always_comb begin
        pg_mod = {3'b000, i_in_data.page};
        for (int k = 0; k < 8; k++) begin
            if (pg_mod >= 9'(PAGES)) begin
                pg_mod = pg_mod - 9'(PAGES);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd <= i_in_data.cmd;
            r_pg  <= pg_mod[PG_W-1:0];
            r_off <= i_in_data.offset;
            r_wd  <= i_in_data.wdata;
        end
    end

    assign row       = {r_pg, r_off[13:LANE_W]};
    assign low       = r_off[11:0];
    assign cur_byte  = ram_rdata[{r_off[LANE_W-1:0], 3'b000} +: 8];
    assign prog_byte = cur_byte & r_wd;

    always_comb begin
        for (int k = 0; k < ROW_BYTES; k++) begin
            merged[k*8 +: 8] = (r_off[LANE_W-1:0] == LANE_W'(k)) ? prog_byte
                                                                  : ram_rdata[k*8 +: 8];
        end
    end

    // sector bounds in rows
    always_comb begin
        aligned = (CNT_W'(r_pg) & ~CNT_W'(3)) << ROW_SEL_W;
        priority if (r_pg < PG_W'(PAGES - 4)) begin
            sec_start = aligned;
            sec_end   = aligned + CNT_W'(BLK_ROWS);
            if (sec_end > CNT_W'(BOOT_ROW)) begin
                sec_end = CNT_W'(BOOT_ROW);
            end
        end else if (r_pg < PG_W'(PAGES - 2)) begin
            sec_start = CNT_W'(BOOT_ROW);
            sec_end   = CNT_W'(P2_ROW);
        end else if (r_pg == PG_W'(PAGES - 2) && !r_off[13]) begin
            sec_start = CNT_W'(P2_ROW);
            sec_end   = CNT_W'(P2_ROW + HALF_PG);
        end else if (r_pg == PG_W'(PAGES - 2)) begin
            sec_start = CNT_W'(P2_ROW + HALF_PG);
            sec_end   = CNT_W'(P1_ROW);
        end else begin
            sec_start = CNT_W'(P1_ROW);
            sec_end   = CNT_W'(FULL_ROW);
        end
    end

    // command decode for the captured transaction
    always_comb begin
        n_step     = r_step;
        n_perr     = r_perr;
        n_lpb      = r_lpb;
        n_tog      = r_tog;
        n_res      = '0;
        prog_we    = 1'b0;
        erase_req  = 1'b0;
        full_erase = 1'b0;
        unique case (r_cmd)
            CMD_READ: begin
                if (r_perr) begin
                    // failed-program status byte
                    n_res  = {~r_lpb[7], r_tog, 1'b1, 5'b00000};
                    n_tog  = ~r_tog;
                    n_perr = 1'b0;
                end else if (r_step == ST_READ || r_step == ST_FAST) begin
                    n_res = cur_byte;
                end else if (r_step == ST_AUTOSEL) begin
                    priority if (r_off == AS_OFF_MFR) begin
                        n_res = ID_MFR;
                    end else if (r_off == AS_OFF_DEVICE) begin
                        n_res = ID_DEVICE;
                    end else if (r_off == AS_OFF_PROT) begin
                        n_res = ID_PROT;
                    end else begin
                        n_res  = ID_PROT;
                        n_step = ST_READ;
                    end
                end else begin
                    // read mid-sequence aborts it
                    n_step = ST_READ;
                    n_res  = cur_byte;
                end
            end
            CMD_WRITE: begin
                if (r_wd == BYTE_RESET && r_step != ST_PROGRAM && r_step != ST_FAST_PROG) begin
                    n_step = ST_READ;
                end else begin
                    n_perr = 1'b0;
                    unique case (r_step)
                        ST_READ: begin
                            n_step = (low == ADDR_UNLOCK1 && r_wd == BYTE_UNLOCK1) ? ST_AA
                                                                                    : ST_READ;
                        end
                        ST_AA: begin
                            n_step = (low == ADDR_UNLOCK2 && r_wd == BYTE_UNLOCK2) ? ST_55
                                                                                    : ST_READ;
                        end
                        ST_55: begin
                            n_step = ST_READ;
                            if (low == ADDR_UNLOCK1) begin
                                priority if (r_wd == BYTE_PROGRAM) begin
                                    n_step = ST_PROGRAM;
                                end else if (r_wd == BYTE_ERASE) begin
                                    n_step = ST_ERASE;
                                end else if (r_wd == BYTE_FAST) begin
                                    n_step = ST_FAST;
                                end else if (r_wd == BYTE_AUTOSEL) begin
                                    n_step = ST_AUTOSEL;
                                end else begin
                                    n_step = ST_READ;
                                end
                            end
                        end
                        ST_PROGRAM, ST_FAST_PROG: begin
                            prog_we = 1'b1;
                            n_lpb   = r_wd;
                            if (prog_byte != r_wd) begin
                                n_perr = 1'b1;
                            end
                            n_step = (r_step == ST_FAST_PROG) ? ST_FAST : ST_READ;
                        end
                        ST_ERASE: begin
                            n_step = (low == ADDR_UNLOCK1 && r_wd == BYTE_UNLOCK1) ? ST_ERASE_AA
                                                                                    : ST_READ;
                        end
                        ST_ERASE_AA: begin
                            n_step = (low == ADDR_UNLOCK2 && r_wd == BYTE_UNLOCK2) ? ST_ERASE_55
                                                                                    : ST_READ;
                        end
                        ST_ERASE_55: begin
                            if (low == ADDR_UNLOCK1 && r_wd == BYTE_CHIP) begin
                                erase_req  = 1'b1;
                                full_erase = 1'b1;
                            end else if (r_wd == BYTE_SECTOR) begin
                                erase_req = 1'b1;
                            end
                            n_step = ST_READ;
                        end
                        ST_FAST: begin
                            priority if (r_wd == BYTE_AUTOSEL) begin
                                n_step = ST_FAST_EXIT;
                            end else if (r_wd == BYTE_PROGRAM) begin
                                n_step = ST_FAST_PROG;
                            end else begin
                                n_step = ST_READ;
                            end
                        end
                        ST_FAST_EXIT: begin
                            n_step = ST_FAST;
                        end
                        default: begin
                            n_step = ST_READ;
                        end
                    endcase
                end
            end
            CMD_FETCH: begin
                n_step = ST_READ;
                n_res  = cur_byte;
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    // array port: program write on decide, blank rows while sweeping
    assign ram_we    = i_ctl.sweep_step || (i_ctl.decide && prog_we);
    assign ram_waddr = i_ctl.sweep_step ? r_sweep_row[ROW_AW-1:0] : row;
    assign ram_wdata = i_ctl.sweep_step ? {ROW_W{1'b1}} : merged;

    fci_ram #(
        .WIDTH (ROW_W),
        .DEPTH (DEPTH)
    ) u_array (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_ctl.lookup),
        .i_raddr (row),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_READ;
            r_perr      <= 1'b0;
            r_lpb       <= '0;
            r_tog       <= 1'b0;
            r_out_valid <= 1'b0;
            r_sweep_row <= '0;
            r_sweep_end <= CNT_W'(FULL_ROW);
        end else begin
            if (i_ctl.decide) begin
                r_step <= n_step;
                r_perr <= n_perr;
                r_lpb  <= n_lpb;
                r_tog  <= n_tog;
                if (erase_req) begin
                    r_sweep_row <= full_erase ? '0 : sec_start;
                    r_sweep_end <= full_erase ? CNT_W'(FULL_ROW) : sec_end;
                end
            end
            if (i_ctl.sweep_step) begin
                r_sweep_row <= r_sweep_row + CNT_W'(1);
            end
            if (i_ctl.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.decide) begin
            r_res <= n_res;
        end
        if (i_ctl.emit) begin
            r_out_data.rdata         <= r_res;
            r_out_data.error_pending <= r_perr;
        end
    end

    assign o_sts.erase_req  = erase_req;
    assign o_sts.sweep_done = (r_sweep_row + CNT_W'(1)) == r_sweep_end;
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

### src/flash_command_interface.sv
// ============================================================================
// flash_command_interface : flash array with unlock-sequence command decoder
// Bus accesses (read, write, fetch) in; one result byte plus program-failure
// flag out per transaction.
// ============================================================================
// Usage:
//  - Input channel i_in_valid / o_in_stall carries one access (cmd, page,
//    offset, wdata). Output channel o_out_valid / i_out_stall returns one
//    result (rdata, error_pending) per access, in order.
//  - Accesses pass through accept, array row read, decode and program
//    write, and result register. One access is in work at a time, so a
//    new access is taken only once the last result has been registered.
//  - Erase: a chip or sector erase blanks the array one 32-byte row per
//    cycle across its range (chip erase covers PAGES*512 rows).
//  - Reset: synchronous, active low. Decoder returns to read-array, status
//    clears, and a fill pass over all PAGES*512 rows sets the whole array to the
//    erased value 0xFF; o_in_stall stays high during the pass.
//  - Stall: a finished result waits in the output register while
//    i_out_stall is high; the next access is still taken and worked on, and
//    only its hand-off waits for the register to drain.
// ============================================================================
`default_nettype none

module flash_command_interface #(
    parameter int PAGES = fci_pkg::PAGES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire fci_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output fci_pkg::t_out_item      o_out_data
);

    import fci_pkg::*;

    t_ctl_cmd ctl;
    t_ctl_sts sts;

    // sequencer: walks each transaction through lookup / decode / sweep / emit
    fci_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    // datapath: decoder state, array RAM, erase counter, output register
    fci_dp #(
        .PAGES (PAGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
